[rtl/rbst_pkg.sv]
// Shared constants and helpers for the ray/box slab test unit.
// Fixed-point format, register indexes and the product rescale/saturate function.
// No dependencies.
package rbst_pkg;

	localparam int FRAC_BITS = 16;               // fraction bits of every Q value
	localparam int VAL_W     = 32;               // coordinate / distance width
	localparam int NUM_AXES  = 3;
	localparam int DIFF_W    = VAL_W + 1;        // exact corner - origin
	localparam int PROD_W    = DIFF_W + VAL_W;   // exact difference * reciprocal
	localparam int SCL_W     = PROD_W - FRAC_BITS;
	localparam int BOX_W     = 2 * NUM_AXES * VAL_W;
	localparam int CFG_IDX_W = 3;

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_DIR_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_DIR_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INV_DIR_Z = 3'd5;

	typedef logic signed [VAL_W-1:0]  val_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	// floor(p / 2^FRAC_BITS), clamped to the signed 32-bit range
	function automatic val_t rescale_sat(input prod_t p);
		logic [SCL_W-1:0] s;
		logic             in_range;
		s        = p[PROD_W-1:FRAC_BITS];
		in_range = (&s[SCL_W-1:VAL_W-1]) || !(|s[SCL_W-1:VAL_W-1]);
		if (in_range) begin
			rescale_sat = val_t'(s[VAL_W-1:0]);
		end else if (s[SCL_W-1]) begin
			rescale_sat = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			rescale_sat = {1'b0, {(VAL_W-1){1'b1}}};
		end
	endfunction

endpackage

[rtl/ray_box_slab_test_unit.sv]
// Ray against axis-aligned box slab test, one box per clock unless stalled, six-register pipeline.
// Depends on rbst_pkg (widths, register indexes, rescale_sat).
//
// The unit holds one ray (origin and per-axis reciprocal direction, signed Q16.16)
// in six configuration registers and tests a stream of boxes against it. Each box
// word carries box_min_x/y/z then box_max_x/y/z, 32 bits each, lowest bits first.
// Each result word carries entry_distance (tmin, Q16.16, 0 on a miss) in tdata and
// the hit flag in tuser. Slab distances are (corner - origin) * inv_dir, floored
// to Q16.16 and saturated to 32 bits; load 0x7FFFFFFF as the reciprocal of a zero
// direction component. Throughput is one box per cycle while the output is not stalled;
// an accepted box passes six registers on its way to the result word: difference,
// multiply, rescale, per-axis order, interval combine, and the output register that
// decides hit. Every stage holds its own valid bit and advances whenever the stage
// after it is empty or moving, so bubbles close up and input is still taken while a
// finished word waits at the output. Write configuration only when no box is in flight.
module ray_box_slab_test_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rbst_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rbst_pkg::VAL_W-1:0]      cfg_data,
	// box input
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z (32 bits each)
	input  logic [rbst_pkg::BOX_W-1:0]      s_axis_tdata,
	// result output
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// entry_distance (32 bits)
	output logic [rbst_pkg::VAL_W-1:0]      m_axis_tdata,
	// hit (1 bit)
	output logic                            m_axis_tuser
);
	import rbst_pkg::*;

	// ray registers
	val_t origin_q [NUM_AXES];
	val_t inv_q    [NUM_AXES];

	// pipeline valid bits and stage enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_out;

	// stage payloads, one lower and one upper slab per axis
	diff_t diff_lo_s1 [NUM_AXES];
	diff_t diff_hi_s1 [NUM_AXES];
	prod_t prod_lo_s2 [NUM_AXES];
	prod_t prod_hi_s2 [NUM_AXES];
	val_t  t_lo_s3    [NUM_AXES];
	val_t  t_hi_s3    [NUM_AXES];
	val_t  near_s4    [NUM_AXES];
	val_t  far_s4     [NUM_AXES];
	val_t  tmin_s5, tmax_s5;

	// output register
	logic  m_valid_q;
	logic  hit_q;
	val_t  dist_q;

	// interval combine (feeds stage 5)
	val_t  tmin_c, tmax_c;

	// configuration: always ready, writes beyond the register list are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				origin_q[a] <= '0;
				inv_q[a]    <= '0;
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ORIGIN_X:  origin_q[0] <= val_t'(cfg_data);
				REG_ORIGIN_Y:  origin_q[1] <= val_t'(cfg_data);
				REG_ORIGIN_Z:  origin_q[2] <= val_t'(cfg_data);
				REG_INV_DIR_X: inv_q[0]    <= val_t'(cfg_data);
				REG_INV_DIR_Y: inv_q[1]    <= val_t'(cfg_data);
				REG_INV_DIR_Z: inv_q[2]    <= val_t'(cfg_data);
				default: ;
			endcase
		end
	end

	// a stage advances when it is empty or the stage after it advances
	assign en_out = !m_valid_q || m_axis_tready;
	assign en_s5  = !v_s5 || en_out;
	assign en_s4  = !v_s4 || en_s5;
	assign en_s3  = !v_s3 || en_s4;
	assign en_s2  = !v_s2 || en_s3;
	assign en_s1  = !v_s1 || en_s2;

	assign s_axis_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (en_s1)  v_s1      <= s_axis_tvalid;
			if (en_s2)  v_s2      <= v_s1;
			if (en_s3)  v_s3      <= v_s2;
			if (en_s4)  v_s4      <= v_s3;
			if (en_s5)  v_s5      <= v_s4;
			if (en_out) m_valid_q <= v_s5;
		end
	end

	// stage 1: exact corner - origin
	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				diff_lo_s1[a] <= diff_t'($signed(s_axis_tdata[a*VAL_W +: VAL_W]))
					- diff_t'(origin_q[a]);
				diff_hi_s1[a] <= diff_t'($signed(s_axis_tdata[(a+NUM_AXES)*VAL_W +: VAL_W]))
					- diff_t'(origin_q[a]);
			end
		end
	end

	// stage 2: exact product with the reciprocal
	always_ff @(posedge clk) begin
		if (en_s2) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				prod_lo_s2[a] <= prod_t'(diff_lo_s1[a]) * prod_t'(inv_q[a]);
				prod_hi_s2[a] <= prod_t'(diff_hi_s1[a]) * prod_t'(inv_q[a]);
			end
		end
	end

	// stage 3: floor to Q format and saturate
	always_ff @(posedge clk) begin
		if (en_s3) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				t_lo_s3[a] <= rescale_sat(prod_lo_s2[a]);
				t_hi_s3[a] <= rescale_sat(prod_hi_s2[a]);
			end
		end
	end

	// stage 4: order the two slab distances of each axis (inverted boxes too)
	always_ff @(posedge clk) begin
		if (en_s4) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				if (t_lo_s3[a] < t_hi_s3[a]) begin
					near_s4[a] <= t_lo_s3[a];
					far_s4[a]  <= t_hi_s3[a];
				end else begin
					near_s4[a] <= t_hi_s3[a];
					far_s4[a]  <= t_lo_s3[a];
				end
			end
		end
	end

	// stage 5: entry is the latest near, exit the earliest far
	always_comb begin
		tmin_c = near_s4[0];
		tmax_c = far_s4[0];
		for (int a = 1; a < NUM_AXES; a++) begin
			if (near_s4[a] > tmin_c) tmin_c = near_s4[a];
			if (far_s4[a] < tmax_c)  tmax_c = far_s4[a];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			tmin_s5 <= tmin_c;
			tmax_s5 <= tmax_c;
		end
	end

	// output register: decide hit, zero the distance on a miss
	always_ff @(posedge clk) begin
		if (en_out) begin
			hit_q  <= (tmax_s5 >= tmin_s5);
			dist_q <= (tmax_s5 >= tmin_s5) ? tmin_s5 : '0;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = dist_q;
	assign m_axis_tuser  = hit_q;

`ifndef SYNTH
	// a miss always carries a zero distance
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
		else $error("miss word with nonzero entry distance");

	// input backpressure only when every stage holds a box
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && m_valid_q)
		else $error("input stalled with a bubble in the pipeline");

	// an accepted box lands in stage 1
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> v_s1)
		else $error("accepted box lost at stage 1");

	// per-axis ordering holds after stage 4
	a_axis_order: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> near_s4[0] <= far_s4[0] && near_s4[1] <= far_s4[1]
			&& near_s4[2] <= far_s4[2])
		else $error("slab distances out of order");

	// a held result word leaves no stage able to drop data
	a_stall_holds_s5: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready && v_s5 |=> v_s5)
		else $error("stage 5 box dropped during output stall");
`endif

endmodule

[bench/tb_ray_box_slab_test_unit.sv]
// Self-checking bench for ray_box_slab_test_unit: streams boxes against a sequence of rays
// and checks each result word against a predictor of the slab test written here.
// Depends on rbst_pkg (value type, register indexes, FRAC_BITS) and the unit RTL.
module tb_ray_box_slab_test_unit;
	import rbst_pkg::*;

	localparam int   LATENCY    = 6;        // box accepted -> result word accepted, no stall
	localparam int   STALL_MAX  = 2000;     // cycles with no word moving on any channel
	localparam int   PRINT_MAX  = 40;       // mismatch lines printed before going quiet
	localparam int   Q_ONE      = 1 << FRAC_BITS;
	localparam val_t V_MAX      = 32'sh7FFF_FFFF;
	localparam val_t V_MIN      = 32'sh8000_0000;
	localparam val_t ZERO_DIR   = 32'sh7FFF_FFFF;   // reciprocal loaded for a zero component

	typedef val_t [NUM_AXES-1:0] vec3_t;
	// lo lands in the low 96 bits, lo[0] (box_min_x) lowest, matching the tdata layout
	typedef struct packed {
		vec3_t hi;
		vec3_t lo;
	} box_t;
	typedef struct packed {
		logic hit;
		val_t entry_dist;
	} hit_rslt_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [VAL_W-1:0]     cfg_data = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [BOX_W-1:0]     s_axis_tdata = '0;   // box_min_x/y/z, box_max_x/y/z
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [VAL_W-1:0]     m_axis_tdata;        // entry_distance
	logic                 m_axis_tuser;        // hit

	// predictor's copy of the ray registers
	val_t      ray_org [NUM_AXES];
	val_t      ray_inv [NUM_AXES];
	hit_rslt_t pending_hits[$];
	hit_rslt_t head_rslt;

	int src_idle_pct  = 0;
	int snk_stall_pct = 0;
	int boxes_sent    = 0;
	int words_checked = 0;
	int hits_seen     = 0;
	int rays_loaded   = 0;
	int mismatches    = 0;
	int quiet_cycles  = 0;

	ray_box_slab_test_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- prediction

	// Distance to one slab plane: exact difference and product, floor by FRAC_BITS,
	// then clamp to the signed 32-bit range.
	function automatic val_t slab_dist(val_t corner, val_t org, val_t inv);
		localparam logic signed [65:0] SAT_HI = 66'sh7FFF_FFFF;
		localparam logic signed [65:0] SAT_LO = -SAT_HI - 66'sd1;
		logic signed [32:0] diff;
		logic signed [65:0] prod;
		logic signed [65:0] scaled;
		diff   = corner - org;
		prod   = diff * inv;
		scaled = prod >>> FRAC_BITS;
		if (scaled > SAT_HI) begin
			return V_MAX;
		end
		if (scaled < SAT_LO) begin
			return V_MIN;
		end
		return scaled[31:0];
	endfunction

	// Entry/exit interval over the three slabs; a miss reports distance 0.
	function automatic hit_rslt_t intersect_box(box_t b);
		hit_rslt_t r;
		val_t      t1, t2, lo_t, hi_t, t_near, t_far;
		int        a;
		t_near = '0;
		t_far  = '0;
		for (a = 0; a < NUM_AXES; a++) begin
			t1   = slab_dist(b.lo[a], ray_org[a], ray_inv[a]);
			t2   = slab_dist(b.hi[a], ray_org[a], ray_inv[a]);
			lo_t = (t1 < t2) ? t1 : t2;
			hi_t = (t1 < t2) ? t2 : t1;
			if (a == 0 || lo_t > t_near) begin
				t_near = lo_t;
			end
			if (a == 0 || hi_t < t_far) begin
				t_far = hi_t;
			end
		end
		r.hit        = (t_far >= t_near);
		r.entry_dist = r.hit ? t_near : '0;
		return r;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(string msg);
		if (mismatches < PRINT_MAX) begin
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		end
		mismatches++;
	endtask

	// Compare every result word with the oldest pending prediction, field by field.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_hits.size() == 0) begin
				report_mismatch($sformatf("unexpected result word hit=%b dist=%h",
					m_axis_tuser, m_axis_tdata));
			end else begin
				head_rslt = pending_hits.pop_front();
				words_checked++;
				if (head_rslt.hit) begin
					hits_seen++;
				end
				if (m_axis_tuser !== head_rslt.hit) begin
					report_mismatch($sformatf("word %0d hit: got %b want %b",
						words_checked, m_axis_tuser, head_rslt.hit));
				end
				if (m_axis_tdata !== head_rslt.entry_dist) begin
					report_mismatch($sformatf("word %0d entry_distance: got %h want %h",
						words_checked, m_axis_tdata, head_rslt.entry_dist));
				end
			end
		end
	end

	// Randomly hold back the result side; the stall rate follows the current phase.
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
	end

	// Abort when no word moves on any channel for too long.
	initial begin
		while (quiet_cycles < STALL_MAX) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			    (cfg_valid && cfg_ready) || !arst_n) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("watchdog: no word moved for %0d cycles", STALL_MAX);
		$display("tb_ray_box_slab_test_unit NOT OK");
		$finish;
	end

	// ---------------------------------------------------------------- drivers

	// Write one ray register; mirror it in the predictor once the word is taken.
	// Leave cfg_valid high so back-to-back writes never toggle it within one step.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, val_t value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		case (idx)
			REG_ORIGIN_X:  ray_org[0] = value;
			REG_ORIGIN_Y:  ray_org[1] = value;
			REG_ORIGIN_Z:  ray_org[2] = value;
			REG_INV_DIR_X: ray_inv[0] = value;
			REG_INV_DIR_Y: ray_inv[1] = value;
			REG_INV_DIR_Z: ray_inv[2] = value;
			default: ;
		endcase
	endtask

	// Load a whole ray; call only with nothing in flight.
	task automatic set_ray(vec3_t org, vec3_t inv);
		write_reg(REG_ORIGIN_X,  org[0]);
		write_reg(REG_ORIGIN_Y,  org[1]);
		write_reg(REG_ORIGIN_Z,  org[2]);
		write_reg(REG_INV_DIR_X, inv[0]);
		write_reg(REG_INV_DIR_Y, inv[1]);
		write_reg(REG_INV_DIR_Z, inv[2]);
		cfg_valid <= 1'b0;
		rays_loaded++;
	endtask

	// Send one box word, with random idle cycles ahead of it, and predict its result.
	task automatic send_box(box_t b);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		pending_hits.push_back(intersect_box(b));
		boxes_sent++;
	endtask

	// Drop valid and hold until every predicted word has been checked.
	task automatic hold_until_empty();
		s_axis_tvalid <= 1'b0;
		while (pending_hits.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Drain, then let the pipeline settle before the next register write.
	task automatic drain();
		hold_until_empty();
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic set_idle(int src_pct, int snk_pct);
		src_idle_pct  = src_pct;
		snk_stall_pct = snk_pct;
	endtask

	function automatic box_t mk_box(val_t lx, val_t ly, val_t lz, val_t hx, val_t hy, val_t hz);
		box_t b;
		b.lo = {lz, ly, lx};
		b.hi = {hz, hy, hx};
		return b;
	endfunction

	function automatic vec3_t mk_vec(val_t x, val_t y, val_t z);
		return {z, y, x};
	endfunction

	// Stimulus-side reciprocal of a direction component; zero loads the largest value.
	function automatic val_t recip_of(val_t d);
		longint q;
		if (d == 0) begin
			return ZERO_DIR;
		end
		q = (longint'(1) <<< (2 * FRAC_BITS)) / longint'(d);
		return q[31:0];
	endfunction

	function automatic val_t rand_dir();
		val_t mag;
		if ($urandom_range(4) == 0) begin
			return '0;
		end
		mag = $urandom_range(Q_ONE / 4, 4 * Q_ONE);
		return $urandom_range(1) ? -mag : mag;
	endfunction

	// Mostly boxes placed on the ray, so the interval logic is exercised past the
	// first slab; the rest are boxes around the origin, loose or inverted boxes
	// nearby, and raw noise across the full field range.
	function automatic box_t random_box(vec3_t org, vec3_t dir);
		box_t   b;
		int     a, kind;
		longint t_q;
		val_t   c, h1, h2;
		kind = $urandom_range(99);
		t_q  = longint'($urandom_range(0, 18 * Q_ONE)) - 2 * Q_ONE;
		for (a = 0; a < NUM_AXES; a++) begin
			h1 = $urandom_range(0, 4 * Q_ONE);
			h2 = $urandom_range(0, 4 * Q_ONE);
			if (kind < 60) begin
				c = $signed(org[a]) + val_t'((t_q * longint'($signed(dir[a]))) >>> FRAC_BITS);
				b.lo[a] = c - h1;
				b.hi[a] = c + h2;
			end else if (kind < 72) begin
				b.lo[a] = org[a] - h1;
				b.hi[a] = org[a] + h2;
			end else if (kind < 87) begin
				c = org[a] + val_t'(int'($urandom_range(0, 16 * Q_ONE)) - 8 * Q_ONE);
				b.lo[a] = c;
				b.hi[a] = c + h1;
			end else if (kind < 95) begin
				c = org[a] + val_t'(int'($urandom_range(0, 16 * Q_ONE)) - 8 * Q_ONE);
				b.lo[a] = c + h1 + 1;
				b.hi[a] = c;
			end else begin
				b.lo[a] = $urandom;
				b.hi[a] = $urandom;
			end
		end
		return b;
	endfunction

	// ---------------------------------------------------------------- tests

	// Registers at reset are all zero: every slab collapses to t = 0, so any box,
	// extremes included, reports a hit at distance 0.
	task automatic test_reset_ray();
		set_idle(0, 0);
		send_box(mk_box(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE));
		send_box(mk_box(V_MIN, V_MAX, V_MIN, V_MAX, V_MIN, V_MAX));
		drain();
	endtask

	// Ray (-4, 0.5, 0) + t * (1, 0.5, -1): boxes ahead, off to the side, around the
	// origin, behind it, inverted, and a flat box touching the ray at one point.
	task automatic test_basic_ray();
		set_ray(mk_vec(-4 * Q_ONE, Q_ONE / 2, 0), mk_vec(Q_ONE, 2 * Q_ONE, -Q_ONE));
		send_box(mk_box(Q_ONE, 3 * Q_ONE, -7 * Q_ONE, 3 * Q_ONE, 4 * Q_ONE, -5 * Q_ONE));
		send_box(mk_box(Q_ONE, -10 * Q_ONE, -7 * Q_ONE, 3 * Q_ONE, -8 * Q_ONE, -5 * Q_ONE));
		send_box(mk_box(-5 * Q_ONE, 0, -Q_ONE, -3 * Q_ONE, Q_ONE, Q_ONE));
		send_box(mk_box(-9 * Q_ONE, -2 * Q_ONE, 3 * Q_ONE, -7 * Q_ONE, -Q_ONE, 5 * Q_ONE));
		// min above max on every axis must order the same as the plain box
		send_box(mk_box(3 * Q_ONE, 4 * Q_ONE, -5 * Q_ONE, Q_ONE, 3 * Q_ONE, -7 * Q_ONE));
		// zero-width in x: entry equals exit
		send_box(mk_box(2 * Q_ONE, 3 * Q_ONE, -7 * Q_ONE, 2 * Q_ONE, 4 * Q_ONE, -5 * Q_ONE));
		drain();
	endtask

	// y direction zero (largest reciprocal), z reciprocal zero (slab pinned to t = 0).
	task automatic test_zero_direction();
		set_ray(mk_vec(Q_ONE, Q_ONE, Q_ONE), mk_vec(Q_ONE, ZERO_DIR, 0));
		send_box(mk_box(2 * Q_ONE, 0, 0, 3 * Q_ONE, 2 * Q_ONE, 2 * Q_ONE));
		send_box(mk_box(0, 0, 0, 3 * Q_ONE, 2 * Q_ONE, 2 * Q_ONE));
		send_box(mk_box(0, 2 * Q_ONE, 0, 3 * Q_ONE, 3 * Q_ONE, 2 * Q_ONE));
		send_box(mk_box(0, Q_ONE, 0, 3 * Q_ONE, 3 * Q_ONE, 2 * Q_ONE));
		drain();
	endtask

	// Extreme origins, reciprocals and corners: products well past 32 bits that must
	// clamp to both ends of the range.
	task automatic test_saturation();
		set_ray(mk_vec(V_MIN, V_MAX, 0), mk_vec(V_MAX, V_MIN, V_MIN));
		send_box(mk_box(V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX));
		send_box(mk_box(V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN));
		send_box(mk_box(V_MIN, V_MIN, V_MIN, V_MAX, V_MAX, V_MAX));
		send_box(mk_box(V_MAX, V_MAX, V_MAX, V_MIN, V_MIN, V_MIN));
		send_box(mk_box(0, 0, 0, 0, 0, 0));
		drain();
		set_ray(mk_vec(V_MAX, V_MIN, V_MAX), mk_vec(V_MIN, V_MAX, V_MAX));
		send_box(mk_box(V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN));
		send_box(mk_box(V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX));
		send_box(mk_box(V_MIN, V_MAX, V_MIN, V_MAX, V_MIN, V_MAX));
		send_box(mk_box(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE));
		send_box(mk_box(V_MAX, 0, V_MIN, 0, V_MAX, 0));
		drain();
	endtask

	// Ten rays, cycling through the four idle/stall mixes. Every third ray is raw
	// 32-bit register noise; the others are built from a direction so boxes can be
	// placed along them. Midway through the second ray, stop feeding until the
	// output side has emptied the pipeline.
	task automatic test_random_rays();
		vec3_t org, inv, dir;
		int    k, n, a;
		for (k = 0; k < 10; k++) begin
			case (k % 4)
				0: set_idle(0, 0);
				1: set_idle(45, 0);
				2: set_idle(0, 45);
				default: set_idle(16, 16);
			endcase
			for (a = 0; a < NUM_AXES; a++) begin
				dir[a] = rand_dir();
				if (k % 3 == 2) begin
					org[a] = $urandom;
					inv[a] = $urandom;
				end else begin
					org[a] = val_t'(int'($urandom_range(0, 200 * Q_ONE)) - 100 * Q_ONE);
					inv[a] = recip_of(dir[a]);
				end
			end
			set_ray(org, inv);
			for (n = 0; n < 55; n++) begin
				send_box(random_box(org, dir));
				if (k == 1 && n == 27) begin
					hold_until_empty();
				end
			end
			drain();
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		ray_org = '{default: '0};
		ray_inv = '{default: '0};

		test_reset_ray();
		test_basic_ray();
		test_zero_direction();
		test_saturation();
		test_random_rays();

		// wait out anything still in the pipeline
		hold_until_empty();
		repeat (LATENCY + 2) @(posedge clk);

		$display("Streamed %0d boxes against %0d rays (reset, directed, zero-direction,",
			boxes_sent, rays_loaded);
		$display("saturating, random) under four idle mixes: %0d words checked, %0d hits.",
			words_checked, hits_seen);
		if (mismatches == 0 && pending_hits.size() == 0) begin
			$display("tb_ray_box_slab_test_unit OK");
		end else begin
			$display("%0d mismatches, %0d words never arrived", mismatches, pending_hits.size());
			$display("tb_ray_box_slab_test_unit NOT OK");
		end
		$finish;
	end

endmodule

[files.f]
rtl/rbst_pkg.sv
rtl/ray_box_slab_test_unit.sv
bench/tb_ray_box_slab_test_unit.sv
